// ===== hw/rtl/tpaa_pkg.sv =====
package tpaa_pkg;

  localparam int POS_WIDTH  = 16;
  localparam int AREA_WIDTH = 48;
  localparam int DELTA_WIDTH = 8;

  // Segment term needs the full product width; the sum gets one guard bit.
  localparam int TERM_WIDTH = 2 * POS_WIDTH;
  localparam int SUM_WIDTH  = ((AREA_WIDTH > TERM_WIDTH) ? AREA_WIDTH : TERM_WIDTH) + 1;

  typedef logic signed [POS_WIDTH-1:0]   pos_t;
  typedef logic signed [AREA_WIDTH-1:0]  area_t;
  typedef logic signed [TERM_WIDTH-1:0]  term_t;
  typedef logic signed [DELTA_WIDTH-1:0] delta_t;
  typedef logic        [1:0]             kind_code_t;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_START = 2'd1,
    KIND_TRACE = 2'd2
  } kind_t;

  // (bx*ay - ax*by)/2, truncated toward zero
  function automatic term_t seg_term(pos_t ax, pos_t ay, pos_t bx, pos_t by);
    logic signed [TERM_WIDTH-1:0] p;
    logic signed [TERM_WIDTH-1:0] q;
    logic signed [TERM_WIDTH:0]   d;
    logic signed [TERM_WIDTH:0]   dr;
    p  = TERM_WIDTH'(bx) * TERM_WIDTH'(ay);
    q  = TERM_WIDTH'(ax) * TERM_WIDTH'(by);
    d  = {p[TERM_WIDTH-1], p} - {q[TERM_WIDTH-1], q};
    // bias negative values by one so the shift rounds toward zero
    dr = d + {{TERM_WIDTH{1'b0}}, d[TERM_WIDTH]};
    return dr[TERM_WIDTH:1];
  endfunction

  function automatic area_t sat_add(area_t a, term_t t);
    logic signed [SUM_WIDTH-1:0] s;
    logic                        fits;
    s    = SUM_WIDTH'(a) + SUM_WIDTH'(t);
    fits = (&s[SUM_WIDTH-1:AREA_WIDTH-1]) | ~(|s[SUM_WIDTH-1:AREA_WIDTH-1]);
    if (fits) begin
      return s[AREA_WIDTH-1:0];
    end
    return {s[SUM_WIDTH-1], {(AREA_WIDTH-1){~s[SUM_WIDTH-1]}}};
  endfunction

endpackage

// ===== hw/rtl/traced_polygon_area_accumulator.sv =====
// Traced polygon area accumulator.
// Input channel (in_valid / in_stall) carries one motion beat: kind selects
// a plain move, the start of a trace, or a trace sample; delta_x / delta_y
// are signed sensor counts. The cursor wraps at the position width.
// Output channel (out_valid / out_stall) returns one beat per input beat:
// the cursor after the beat and the running shoelace area closed back to
// the first traced point, saturated at the area range.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while the receiver does not stall; all state
// updates within that cycle, set by the cursor adder feeding the two segment
// multipliers and the saturating area adds.
// When the receiver stalls, the result register holds and in_stall rises
// only while a result is waiting and stalled; a beat is taken in the same
// cycle the waiting result leaves.
// Reset (rst, synchronous) clears cursor, first and last point, the area
// and the output valid.
module traced_polygon_area_accumulator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tpaa_pkg::kind_code_t   kind,
  input  tpaa_pkg::delta_t       delta_x,
  input  tpaa_pkg::delta_t       delta_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tpaa_pkg::pos_t         pos_x,
  output tpaa_pkg::pos_t         pos_y,
  output tpaa_pkg::area_t        closed_area
);
  import tpaa_pkg::*;

  pos_t  cursor_x, cursor_y, prev_x, prev_y, origin_x, origin_y;
  area_t area_sum;

  pos_t  cursor_x_next, cursor_y_next, prev_x_next, prev_y_next;
  pos_t  origin_x_next, origin_y_next;
  area_t area_sum_next, closed_area_next;
  pos_t  moved_x, moved_y;
  term_t step_term, close_term;
  logic  accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign moved_x   = cursor_x + POS_WIDTH'(delta_x);
  assign moved_y   = cursor_y + POS_WIDTH'(delta_y);
  assign step_term = seg_term(moved_x, moved_y, prev_x, prev_y);

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    prev_x_next   = prev_x;
    prev_y_next   = prev_y;
    origin_x_next = origin_x;
    origin_y_next = origin_y;
    area_sum_next = area_sum;
    unique case (kind)
      KIND_MOVE: begin
        cursor_x_next = moved_x;
        cursor_y_next = moved_y;
      end
      KIND_START: begin
        prev_x_next   = cursor_x;
        prev_y_next   = cursor_y;
        origin_x_next = cursor_x;
        origin_y_next = cursor_y;
        area_sum_next = '0;
      end
      KIND_TRACE: begin
        cursor_x_next = moved_x;
        cursor_y_next = moved_y;
        prev_x_next   = moved_x;
        prev_y_next   = moved_y;
        area_sum_next = sat_add(area_sum, step_term);
      end
      default: begin
      end
    endcase
  end

  // closing segment from last point back to the first one
  assign close_term       = seg_term(origin_x_next, origin_y_next, prev_x_next, prev_y_next);
  assign closed_area_next = sat_add(area_sum_next, close_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      origin_x <= '0;
      origin_y <= '0;
      area_sum <= '0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      prev_x   <= prev_x_next;
      prev_y   <= prev_y_next;
      origin_x <= origin_x_next;
      origin_y <= origin_y_next;
      area_sum <= area_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x       <= cursor_x_next;
      pos_y       <= cursor_y_next;
      closed_area <= closed_area_next;
    end
  end

`ifndef ASSERT_OFF
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_START |=> out_valid && closed_area == '0)
    else $error("start beat did not report zero area");

  a_move_keeps_area: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_MOVE |=> $stable(area_sum) && $stable(prev_x) && $stable(prev_y))
    else $error("move beat changed the trace state");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result register");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  import tpaa_pkg::*;

  localparam kind_code_t KIND_UNUSED = 2'd3;
  localparam delta_t     DELTA_MAX   = 127;
  localparam delta_t     DELTA_MIN   = -128;
  localparam pos_t       POS_MAX     = 32767;
  localparam pos_t       POS_MIN     = -32768;
  localparam longint     AREA_HI     = (longint'(1) <<< (AREA_WIDTH - 1)) - 1;
  localparam longint     AREA_LO     = -AREA_HI - 1;
  // one lap around the wrapped corners adds close to 2^32 to the area
  localparam int         CORNER_LAPS = 4;
  localparam int         RANDOM_BEATS = 200;

  typedef struct {
    pos_t  x;
    pos_t  y;
    area_t area;
  } result_t;

  typedef struct {
    kind_code_t k;
    delta_t     dx;
    delta_t     dy;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  kind_code_t kind;
  delta_t     delta_x;
  delta_t     delta_y;
  logic       out_valid;
  logic       out_stall;
  pos_t       pos_x;
  pos_t       pos_y;
  area_t      closed_area;

  traced_polygon_area_accumulator DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .closed_area (closed_area)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow state of the tracer
  pos_t  cur_x = '0;
  pos_t  cur_y = '0;
  pos_t  last_x = '0;
  pos_t  last_y = '0;
  pos_t  first_x = '0;
  pos_t  first_y = '0;
  area_t area_acc = '0;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  result_t   blank;
  int        failures = 0;
  bit        sender_idles = 1'b1;
  bit        long_hold_req = 1'b0;

  // cross(a, b) / 2, truncated toward zero
  function automatic longint half_cross(pos_t ax, pos_t ay, pos_t bx, pos_t by);
    return (longint'(ax) * longint'(by) - longint'(bx) * longint'(ay)) / 2;
  endfunction

  function automatic area_t add_sat(area_t a, longint t);
    longint s;
    s = longint'(a) + t;
    if (s > AREA_HI) return area_t'(AREA_HI);
    if (s < AREA_LO) return area_t'(AREA_LO);
    return area_t'(s);
  endfunction

  task automatic advance_tracer(input kind_code_t k, input delta_t dx, input delta_t dy,
                                output result_t r);
    if (k == KIND_MOVE || k == KIND_TRACE) begin
      cur_x = cur_x + pos_t'(dx);
      cur_y = cur_y + pos_t'(dy);
    end
    if (k == KIND_START) begin
      area_acc = '0;
      first_x  = cur_x;
      first_y  = cur_y;
      last_x   = cur_x;
      last_y   = cur_y;
    end else if (k == KIND_TRACE) begin
      area_acc = add_sat(area_acc, half_cross(last_x, last_y, cur_x, cur_y));
      last_x   = cur_x;
      last_y   = cur_y;
    end
    r.x    = cur_x;
    r.y    = cur_y;
    r.area = add_sat(area_acc, half_cross(last_x, last_y, first_x, first_y));
  endtask

  function automatic void add_row(kind_code_t k, int dx, int dy, bit typed = 1'b0,
                                  int ex = 0, int ey = 0, longint ea = 0);
    stim_row_t row;
    row.k         = k;
    row.dx        = delta_t'(dx);
    row.dy        = delta_t'(dy);
    row.typed     = typed;
    row.want.x    = pos_t'(ex);
    row.want.y    = pos_t'(ey);
    row.want.area = area_t'(ea);
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic delta_t rand_delta();
    return delta_t'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input kind_code_t k, input delta_t dx, input delta_t dy,
                           input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind     <= k;
    delta_x  <= dx;
    delta_y  <= dy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    advance_tracer(k, dx, dy, pred);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic beat(input kind_code_t k, input delta_t dx, input delta_t dy);
    send_beat(k, dx, dy, 1'b0, blank);
  endtask

  // walk the cursor to a point with plain moves, wrapping the short way
  task automatic move_to(input pos_t tx, input pos_t ty);
    pos_t   ddx;
    pos_t   ddy;
    delta_t sx;
    delta_t sy;
    while (cur_x != tx || cur_y != ty) begin
      ddx = tx - cur_x;
      ddy = ty - cur_y;
      sx  = (ddx > 127) ? DELTA_MAX : (ddx < -128) ? DELTA_MIN : delta_t'(ddx);
      sy  = (ddy > 127) ? DELTA_MAX : (ddy < -128) ? DELTA_MIN : delta_t'(ddy);
      beat(KIND_MOVE, sx, sy);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall pattern, plus one long hold on request
  initial begin
    int busy_left;
    int free_left;
    busy_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        free_left     = 0;
        busy_left     = 80;
      end else if (busy_left == 0 && free_left == 0) begin
        free_left = $urandom_range(1, 30);
        busy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 3);
      end
      if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b1;
        busy_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: pos_x %0d pos_y %0d area %0d",
                 $time, pos_x, pos_y, closed_area);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (pos_x !== want.x) begin
          $display("%0t: pos_x expected %0d, got %0d", $time, want.x, pos_x);
          failures++;
        end
        if (pos_y !== want.y) begin
          $display("%0t: pos_y expected %0d, got %0d", $time, want.y, pos_y);
          failures++;
        end
        if (closed_area !== want.area) begin
          $display("%0t: closed_area expected %0d, got %0d", $time, want.area, closed_area);
          failures++;
        end
      end
    end
  end

  initial begin
    int         made;
    int         n;
    kind_code_t k;
    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = KIND_MOVE;
    delta_x  = '0;
    delta_y  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(KIND_UNUSED,    5,   -5, 1'b1,   0,    0, 0);
    add_row(KIND_MOVE,    127,  127, 1'b1, 127,  127, 0);
    add_row(KIND_MOVE,   -128, -128, 1'b1,  -1,   -1, 0);
    add_row(KIND_START,    99,   -7, 1'b1,  -1,   -1, 0);
    add_row(KIND_TRACE,   127,    0);
    add_row(KIND_TRACE,     0,  127);
    add_row(KIND_TRACE,     0,    0);
    add_row(KIND_MOVE,      1,    1);
    add_row(KIND_TRACE,  -128,    0);
    add_row(KIND_TRACE,     0, -128);
    add_row(KIND_UNUSED, -128,  127);
    add_row(KIND_TRACE,    -1,    1);
    add_row(KIND_TRACE,     1,   -1);
    add_row(KIND_START,  -128,  127, 1'b1,  -1,   -1, 0);
    add_row(KIND_MOVE,    127, -128, 1'b1, 126, -129, 0);
    add_row(KIND_TRACE,     0,    0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].k, directed_rows[i].dx, directed_rows[i].dy,
                directed_rows[i].typed, directed_rows[i].want);

    // mostly well-formed traces with random motion, some stray beats
    long_hold_req = 1'b1;
    made = 0;
    while (made < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 7) begin
        beat(KIND_START, rand_delta(), rand_delta());
        made++;
        n = $urandom_range(2, 12);
        repeat (n) begin
          beat(($urandom_range(0, 4) == 0) ? KIND_MOVE : KIND_TRACE,
               rand_delta(), rand_delta());
          made++;
        end
      end else begin
        k = kind_code_t'($urandom_range(0, 3));
        beat(k, rand_delta(), rand_delta());
        if (k != KIND_UNUSED) made++;
      end
    end
    quiesce();

    // circle the wrapped corners both ways for the largest segment terms
    sender_idles = 1'b0;
    move_to(POS_MAX, POS_MIN);
    beat(KIND_START, 0, 0);
    repeat (CORNER_LAPS) begin
      beat(KIND_TRACE, 0, -1);
      beat(KIND_TRACE, 1, 0);
      beat(KIND_TRACE, 0, 1);
      beat(KIND_TRACE, -1, 0);
    end
    beat(KIND_START, 0, 0);
    repeat (CORNER_LAPS) begin
      beat(KIND_TRACE, 1, 0);
      beat(KIND_TRACE, 0, -1);
      beat(KIND_TRACE, -1, 0);
      beat(KIND_TRACE, 0, 1);
    end
    quiesce();
    repeat (5) @(posedge clk);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tpaa_pkg.sv
hw/rtl/traced_polygon_area_accumulator.sv
verif/tb.sv
